### rtl/core/rdp_pkg.sv
// shared types, widths and constants of the red drop probability block
`default_nettype none

package rdp_pkg;

  // field widths
  localparam int QLEN_W = 16;
  localparam int AVG_W  = 32;
  localparam int PROB_W = 17;
  localparam int CNT_W  = 16;
  localparam int THR_W  = 16;
  localparam int DEC_W  = 2;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // shared divider widths
  localparam int DIV_D_W   = 17;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_N_W   = DIV_D_W + DIV_Q_W;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_Q_W);

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 72;

  // fixed point one in Q1.16
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [CNT_W-1:0]  CNT_MAX = 16'hFFFF;

  // register reset values
  localparam logic [THR_W-1:0]  AVG_WEIGHT_RST = 16'd131;
  localparam logic [THR_W-1:0]  MIN_THR_RST    = 16'd10;
  localparam logic [THR_W-1:0]  MAX_THR_RST    = 16'd30;
  localparam logic [PROB_W-1:0] MAX_PROB_RST   = 17'd1638;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_AVG_WEIGHT = 2'd0,
    REG_MIN_THR    = 2'd1,
    REG_MAX_THR    = 2'd2,
    REG_MAX_PROB   = 2'd3
  } reg_idx_t;

  // packet decisions
  typedef enum logic [DEC_W-1:0] {
    DEC_ENQUEUE = 2'd0,
    DEC_TEST    = 2'd1,
    DEC_DROP    = 2'd2
  } decision_t;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  // status from the shared divider
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/rdp_mul_unit.sv
// shared registered multiplier, 17 by 32 bits
`default_nettype none

module rdp_mul_unit (
  input  wire logic                        clk,
  input  wire logic [rdp_pkg::MUL_A_W-1:0] op_a,
  input  wire logic [rdp_pkg::MUL_B_W-1:0] op_b,
  output logic      [rdp_pkg::MUL_P_W-1:0] prod
);
  import rdp_pkg::*;

  // product register, valid in the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

`default_nettype wire

### rtl/core/rdp_div_unit.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module rdp_div_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rdp_pkg::div_req_t req,
  output rdp_pkg::div_rsp_t      rsp
);
  import rdp_pkg::*;

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_Q_W-1:0]   low;
  logic [DIV_D_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_D_W:0]     trial;
  logic                 fits;
  logic [DIV_D_W:0]     diff;

  // one trial subtraction per step
  always_comb begin
    trial = {rem, low[DIV_Q_W-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[DIV_N_W-1:DIV_Q_W];
      low     <= req.dividend[DIV_Q_W-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      low <= {low[DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = low;

endmodule

`default_nettype wire

### rtl/core/red_drop_probability.sv
// top level: config registers, sequencer and state of the red drop probability block
//
// One packet arrival in on the slave stream gives one decision out on the master stream:
// enqueue, probabilistic drop test or forced drop, with the held marked and base drop
// probabilities (Q1.16) and the updated average queue length (Q16.16). The block takes
// one arrival at a time and drops s_tready until its result has been taken. An arrival
// that ends in enqueue or forced drop goes through AVG_OLD, AVG_NEW, AVG_SUM and CMP to
// OUT; one in the band between the thresholds goes on through PB_PROD, PB_DIV, PA_PROD,
// PA_CHK and, unless the marked probability saturates, PA_DIV. The shared 17 by 32
// multiplier and the shared restoring divider, which resolves one quotient bit per cycle,
// serve the band path; the divider computes the base and then, without saturation, the
// marked probability. Configuration registers sit on the APB port at byte addresses 0, 4,
// 8 and 12 and are to be written while idle; the block itself does not enforce this.
`default_nettype none

module red_drop_probability (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rdp_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rdp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rdp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // arrivals: queue_length
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rdp_pkg::S_TDATA_W-1:0]     s_tdata,
  // decisions: decision, marked_probability, base_probability, average_queue, zero pad
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [rdp_pkg::M_TDATA_W-1:0]     m_tdata
);
  import rdp_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_AVG_OLD = 11'b000_0000_0010,
    ST_AVG_NEW = 11'b000_0000_0100,
    ST_AVG_SUM = 11'b000_0000_1000,
    ST_CMP     = 11'b000_0001_0000,
    ST_PB_PROD = 11'b000_0010_0000,
    ST_PB_DIV  = 11'b000_0100_0000,
    ST_PA_PROD = 11'b000_1000_0000,
    ST_PA_CHK  = 11'b001_0000_0000,
    ST_PA_DIV  = 11'b010_0000_0000,
    ST_OUT     = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [THR_W-1:0]  avg_weight;
  logic [THR_W-1:0]  min_threshold;
  logic [THR_W-1:0]  max_threshold;
  logic [PROB_W-1:0] max_probability;

  // block state
  logic [AVG_W-1:0]  avg_queue;
  logic [CNT_W-1:0]  since_drop_count;
  logic [PROB_W-1:0] base_prob;
  logic [PROB_W-1:0] marked_prob;
  decision_t         decision;

  // working registers
  logic [QLEN_W-1:0]  queue_length;
  logic [MUL_P_W-1:0] acc;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // derived values
  reg_idx_t           cfg_idx;
  logic               cfg_write;
  logic [AVG_W-1:0]   min_fx;
  logic [AVG_W-1:0]   max_fx;
  logic [PROB_W-1:0]  maxp;
  logic [AVG_W-1:0]   above_min;
  logic [MUL_P_W-1:0] avg_sum;
  logic [PROB_W-1:0]  pa_den;
  logic               pa_sat;
  logic               in_band;

  rdp_mul_unit u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  rdp_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration access
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_weight      <= AVG_WEIGHT_RST;
      min_threshold   <= MIN_THR_RST;
      max_threshold   <= MAX_THR_RST;
      max_probability <= MAX_PROB_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_AVG_WEIGHT: avg_weight      <= pwdata[THR_W-1:0];
        REG_MIN_THR:    min_threshold   <= pwdata[THR_W-1:0];
        REG_MAX_THR:    max_threshold   <= pwdata[THR_W-1:0];
        REG_MAX_PROB:   max_probability <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AVG_WEIGHT: prdata = APB_DATA_W'(avg_weight);
      REG_MIN_THR:    prdata = APB_DATA_W'(min_threshold);
      REG_MAX_THR:    prdata = APB_DATA_W'(max_threshold);
      REG_MAX_PROB:   prdata = APB_DATA_W'(max_probability);
      default:        prdata = '0;
    endcase
  end

  // thresholds in Q16.16 and clamped max probability
  assign min_fx    = {min_threshold, 16'h0000};
  assign max_fx    = {max_threshold, 16'h0000};
  assign maxp      = (max_probability > ONE_Q16) ? ONE_Q16 : max_probability;
  assign above_min = avg_queue - min_fx;
  assign in_band   = (avg_queue >= min_fx) && (avg_queue < max_fx);

  // old-average term plus shifted new-sample term
  assign avg_sum = acc + {prod[MUL_P_W-17:0], 16'h0000};

  // marked probability denominator and overflow check
  assign pa_den = ONE_Q16 - prod[PROB_W-1:0];
  assign pa_sat = (prod[MUL_P_W-1:16] != '0) || ({1'b0, base_prob[PROB_W-1:1]} >= pa_den);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_AVG_OLD: begin
        mul_a = ONE_Q16 - {1'b0, avg_weight};
        mul_b = avg_queue;
      end
      ST_AVG_NEW: begin
        mul_a = {1'b0, avg_weight};
        mul_b = MUL_B_W'(queue_length);
      end
      ST_CMP: begin
        mul_a = maxp;
        mul_b = above_min;
      end
      ST_PA_PROD: begin
        mul_a = base_prob;
        mul_b = MUL_B_W'(since_drop_count);
      end
      default: ;
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    if (state == ST_PB_PROD) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'(prod[MUL_P_W-1:16]);
      div_req.divisor  = {1'b0, max_threshold - min_threshold};
    end else if (state == ST_PA_CHK && !pa_sat) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'({base_prob, 16'h0000});
      div_req.divisor  = pa_den;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_AVG_OLD;
      ST_AVG_OLD: state_next = ST_AVG_NEW;
      ST_AVG_NEW: state_next = ST_AVG_SUM;
      ST_AVG_SUM: state_next = ST_CMP;
      ST_CMP:     state_next = in_band ? ST_PB_PROD : ST_OUT;
      ST_PB_PROD: state_next = ST_PB_DIV;
      ST_PB_DIV:  if (div_rsp.done) state_next = ST_PA_PROD;
      ST_PA_PROD: state_next = ST_PA_CHK;
      ST_PA_CHK:  state_next = pa_sat ? ST_OUT : ST_PA_DIV;
      ST_PA_DIV:  if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:     if (m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // block state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_queue        <= '0;
      since_drop_count <= '0;
      base_prob        <= '0;
      marked_prob      <= '0;
      decision         <= DEC_ENQUEUE;
    end else begin
      unique case (state)
        ST_AVG_SUM: avg_queue <= avg_sum[47:16];
        ST_CMP: begin
          if (avg_queue < min_fx) begin
            since_drop_count <= '0;
            decision         <= DEC_ENQUEUE;
          end else if (avg_queue < max_fx) begin
            if (since_drop_count != CNT_MAX) begin
              since_drop_count <= since_drop_count + 1'b1;
            end
            decision <= DEC_TEST;
          end else begin
            since_drop_count <= '0;
            decision         <= DEC_DROP;
          end
        end
        ST_PB_DIV: if (div_rsp.done) base_prob <= div_rsp.quotient;
        ST_PA_CHK: if (pa_sat) marked_prob <= ONE_Q16;
        ST_PA_DIV: begin
          if (div_rsp.done) begin
            marked_prob <= (div_rsp.quotient > ONE_Q16) ? ONE_Q16 : div_rsp.quotient;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      queue_length <= s_tdata[QLEN_W-1:0];
    end
    if (state == ST_AVG_NEW) begin
      acc <= prod;
    end
  end

  // stream handshakes and result payload
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {4'h0, avg_queue, base_prob, marked_prob, decision};

endmodule

`default_nettype wire
